[rtl/lus_pkg.sv]
// package for the longest unique substring unit
// types, widths and constants shared by the queue, the core and the top level
`timescale 1ns / 1ps

package lus_pkg;

  localparam int IndexWidth = 16;
  localparam int ByteWidth  = 8;
  localparam int NumBytes   = 256;
  localparam int LenWidth   = 9;
  localparam int LenCap     = 256;
  localparam int QueueDepth = 2;
  localparam int QPtrWidth  = $clog2(QueueDepth);
  localparam int QCntWidth  = $clog2(QueueDepth + 1);

  typedef logic [IndexWidth-1:0] idx_t;
  typedef logic [LenWidth-1:0]   len_t;
  typedef logic [ByteWidth-1:0]  byte_t;

  localparam idx_t IdxMax = '1;

  typedef struct packed {
    logic  is_last;
    byte_t char_byte;
  } lus_item_t;

  typedef struct packed {
    logic      valid;
    lus_item_t item;
  } lus_q_t;

endpackage

[rtl/lus_front.sv]
// front end of the longest unique substring unit: input beat acceptance and byte queue
// depends on lus_pkg
`timescale 1ns / 1ps

module lus_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  lus_pkg::byte_t      in_byte,
  input  logic                in_last,
  output lus_pkg::lus_q_t     q_head,
  input  logic                q_pop
);

  lus_pkg::lus_item_t              q_mem [lus_pkg::QueueDepth];
  logic [lus_pkg::QPtrWidth-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [lus_pkg::QPtrWidth-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [lus_pkg::QCntWidth-1:0]   cnt_r, cnt_nxt;
  logic                            push;
  logic                            pop;

  assign in_tready = (cnt_r < lus_pkg::QCntWidth'(lus_pkg::QueueDepth));
  assign push      = in_tvalid && in_tready;
  assign pop       = q_pop && (cnt_r != '0);

  assign q_head.valid = (cnt_r != '0);
  assign q_head.item  = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == lus_pkg::QPtrWidth'(lus_pkg::QueueDepth - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == lus_pkg::QPtrWidth'(lus_pkg::QueueDepth - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= '{is_last: in_last, char_byte: in_byte};
    end
  end

endmodule

[rtl/lus_core.sv]
// back end of the longest unique substring unit: last-seen table, window tracking, result register
// depends on lus_pkg; fed by lus_front
`timescale 1ns / 1ps

module lus_core (
  input  logic              clk,
  input  logic              rst_n,
  input  lus_pkg::lus_q_t   q_head,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output lus_pkg::len_t     out_len,
  output logic              out_ovf
);

  // last-seen index table, no reset
  lus_pkg::idx_t tbl_mem [lus_pkg::NumBytes];

  // read stage
  logic                    rd_vld_r;
  lus_pkg::byte_t          rd_byte_r;
  logic                    rd_last_r;
  lus_pkg::idx_t           rd_data_r;
  logic                    fwd_hit_r;
  lus_pkg::idx_t           fwd_data_r;

  // string state
  logic [lus_pkg::NumBytes-1:0] seen_r, seen_nxt;
  lus_pkg::idx_t           ws_r, ws_nxt;
  lus_pkg::idx_t           pos_r, pos_nxt;
  lus_pkg::len_t           best_r, best_nxt;
  logic                    ovf_r, ovf_nxt;

  // result register
  logic                    out_vld_r;
  lus_pkg::len_t           out_len_r;
  logic                    out_ovf_r;

  logic                    exe_go;
  lus_pkg::idx_t           prev;
  logic                    in_window;
  lus_pkg::idx_t           ws_new;
  lus_pkg::idx_t           diff;
  lus_pkg::len_t           len;
  lus_pkg::len_t           best_upd;
  logic                    ovf_upd;

  assign exe_go = rd_vld_r && (!rd_last_r || !out_vld_r || out_tready);
  assign q_pop  = q_head.valid && (!rd_vld_r || exe_go);

  always_comb begin
    prev      = fwd_hit_r ? fwd_data_r : rd_data_r;
    in_window = seen_r[rd_byte_r] && (prev >= ws_r);
    ws_new    = ws_r;
    if (in_window) begin
      ws_new = (prev == lus_pkg::IdxMax) ? lus_pkg::IdxMax : prev + 1'b1;
    end
    diff = pos_r - ws_new;
    if (ws_new > pos_r) begin
      len = lus_pkg::len_t'(1);
    end else if (diff > lus_pkg::idx_t'(lus_pkg::LenCap - 1)) begin
      len = lus_pkg::len_t'(lus_pkg::LenCap);
    end else begin
      len = lus_pkg::len_t'(diff[lus_pkg::ByteWidth-1:0]) + 1'b1;
    end
    best_upd = (len > best_r) ? len : best_r;
    ovf_upd  = ovf_r || (pos_r == lus_pkg::IdxMax);

    seen_nxt = seen_r;
    ws_nxt   = ws_r;
    pos_nxt  = pos_r;
    best_nxt = best_r;
    ovf_nxt  = ovf_r;
    if (exe_go) begin
      if (rd_last_r) begin
        seen_nxt = '0;
        ws_nxt   = '0;
        pos_nxt  = '0;
        best_nxt = '0;
        ovf_nxt  = 1'b0;
      end else begin
        seen_nxt[rd_byte_r] = 1'b1;
        ws_nxt   = ws_new;
        pos_nxt  = (pos_r == lus_pkg::IdxMax) ? pos_r : pos_r + 1'b1;
        best_nxt = best_upd;
        ovf_nxt  = ovf_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r  <= 1'b0;
      seen_r    <= '0;
      ws_r      <= '0;
      pos_r     <= '0;
      best_r    <= '0;
      ovf_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (q_pop) begin
        rd_vld_r <= 1'b1;
      end else if (exe_go) begin
        rd_vld_r <= 1'b0;
      end
      seen_r <= seen_nxt;
      ws_r   <= ws_nxt;
      pos_r  <= pos_nxt;
      best_r <= best_nxt;
      ovf_r  <= ovf_nxt;
      if (exe_go && rd_last_r) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // table write on execute, registered read on pop with write forwarding
  always_ff @(posedge clk) begin
    if (exe_go) begin
      tbl_mem[rd_byte_r] <= pos_r;
    end
    if (q_pop) begin
      rd_data_r  <= tbl_mem[q_head.item.char_byte];
      rd_byte_r  <= q_head.item.char_byte;
      rd_last_r  <= q_head.item.is_last;
      fwd_hit_r  <= exe_go && (rd_byte_r == q_head.item.char_byte);
      fwd_data_r <= pos_r;
    end
    if (exe_go && rd_last_r) begin
      out_len_r <= best_upd;
      out_ovf_r <= ovf_upd;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_len    = out_len_r;
  assign out_ovf    = out_ovf_r;

  a_ws_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
    ws_r <= pos_r)
    else $error("window start passed position");

  a_best_cap: assert property (@(posedge clk) disable iff (!rst_n)
    best_r <= lus_pkg::len_t'(lus_pkg::LenCap))
    else $error("best length above cap");

  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    exe_go && rd_last_r |=> (pos_r == '0) && (seen_r == '0) && !ovf_r)
    else $error("string state not cleared after last beat");

  a_result_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    exe_go && rd_last_r |=> out_vld_r && (out_len_r != '0))
    else $error("missing result after last beat");

endmodule

[rtl/longest_unique_substring_unit.sv]
// longest unique substring unit: top level, packs stream beats for lus_front and lus_core
// result path: byte queue, read stage, then the result register that drives out_tvalid
// throughput: one byte beat per cycle while results are taken, set by the one read and
// one write port of the last-seen table, with write forwarding between neighboring beats
// reset: clears queue, pipeline, seen marks and string state; the table is not cleared
// and needs no clearing pass, so bytes are taken from the first cycle after reset
`timescale 1ns / 1ps

module longest_unique_substring_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // char_byte[7:0]
  input  logic        in_tlast,   // is_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // longest_length[8:0], zero[15:9]
  output logic        out_tuser   // overflow
);

  lus_pkg::lus_q_t q_head;
  logic            q_pop;
  lus_pkg::len_t   out_len;

  lus_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .q_head    (q_head),
    .q_pop     (q_pop)
  );

  lus_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_len    (out_len),
    .out_ovf    (out_tuser)
  );

  assign out_tdata = {(16 - lus_pkg::LenWidth)'(0), out_len};

endmodule
